// ----- rtl/sawtooth_contrast_stretch_macros.svh -----
// Assertion macros for the sawtooth contrast stretch checker
`ifndef SAWTOOTH_CONTRAST_STRETCH_MACROS_SVH
`define SAWTOOTH_CONTRAST_STRETCH_MACROS_SVH

// same-cycle implication, switched off while rst is high
`define SCS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scs assertion failed");

// next-cycle implication, switched off while rst is high
`define SCS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scs assertion failed");

`endif

// ----- rtl/scs_pkg.sv -----
// Package: widths, codes and pipeline control type for the contrast stretch
`timescale 1ns / 1ps
`default_nettype none
package scs_pkg;

   localparam int PIX_W          = 8;
   localparam int BOUND_W        = 9;
   localparam int HIT_W          = 3;
   localparam int SEG_MAX        = 4;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 9;
   localparam int BITS_PER_STAGE = 3;

   localparam logic [HIT_W-1:0] NO_HIT = 3'd4;

   typedef struct packed {
      logic load;
      logic valid;
   } stage_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/scs_channels.sv -----
// Stream interfaces for the pixel request and result channels
`timescale 1ns / 1ps
`default_nettype none
interface scs_req_if;
   logic                         valid;
   logic                         ready;
   logic [scs_pkg::PIX_W-1:0]    gray_in;

   modport source (output valid, output gray_in, input ready);
   modport sink   (input valid, input gray_in, output ready);
endinterface

interface scs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [scs_pkg::PIX_W-1:0]    gray_out;
   logic [scs_pkg::HIT_W-1:0]    segment_hit;

   modport source (output valid, output gray_out, output segment_hit, input ready);
   modport sink   (input valid, input gray_out, input segment_hit, output ready);
endinterface
`default_nettype wire

// ----- rtl/sawtooth_contrast_stretch.sv -----
// Each accepted pixel is registered by the match, multiply, divider and rounding stages in order.
// Throughput: one pixel per cycle while the result is not stalled; the pipeline is set by the
// restoring divider, three quotient bits per stage, between the multiplier and the rounding stage.
// Each stage advances on its own, so bubbles close up behind a stalled result.
// Synchronous reset empties the pipeline and clears all segment bounds to zero.
`timescale 1ns / 1ps
`default_nettype none
module sawtooth_contrast_stretch #(
   parameter int NUM_SEGMENTS = 4,
   parameter int OUT_SCALE    = 299
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   scs_req_if.sink                                   req_chan,
   scs_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_we,
   input  wire logic [scs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [scs_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int QUO_W      = (OUT_SCALE > 1) ? $clog2(OUT_SCALE) : 1;
   localparam int SCALE_W    = $clog2(OUT_SCALE + 1);
   localparam int NUM_W      = scs_pkg::PIX_W + SCALE_W;
   localparam int BPS        = scs_pkg::BITS_PER_STAGE;
   localparam int DIV_STAGES = (QUO_W + BPS - 1) / BPS;
   localparam int NST        = DIV_STAGES + 3;
   localparam int SEG_SEL_W  = scs_pkg::CSR_INDEX_W - 1;

   // segment bound registers
   logic [NUM_SEGMENTS-1:0][scs_pkg::BOUND_W-1:0] seg_low_ff;
   logic [NUM_SEGMENTS-1:0][scs_pkg::BOUND_W-1:0] seg_high_ff;

   for (genvar i = 0; i < NUM_SEGMENTS; i++) begin : g_seg
      always_ff @(posedge clock) begin
         if (reset) begin
            seg_low_ff[i]  <= '0;
            seg_high_ff[i] <= '0;
         end else if (csr_we && csr_index[scs_pkg::CSR_INDEX_W-1:1] == SEG_SEL_W'(i)) begin
            if (csr_index[0]) begin
               seg_high_ff[i] <= csr_wdata;
            end else begin
               seg_low_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // pipeline control: a stage loads when empty or when the next one loads
   logic [NST-1:0]             stage_en;
   logic [NST-1:0]             stage_valid;
   scs_pkg::stage_ctl_type     stage_ctl [NST];

   assign stage_en[NST-1] = !stage_valid[NST-1] || rsp_chan.ready;
   for (genvar k = 0; k < NST - 1; k++) begin : g_en
      assign stage_en[k] = !stage_valid[k] || stage_en[k+1];
   end

   for (genvar k = 0; k < NST; k++) begin : g_ctl
      assign stage_ctl[k].load = stage_en[k];
      if (k == 0) begin : g_first
         assign stage_ctl[k].valid = req_chan.valid;
      end else begin : g_rest
         assign stage_ctl[k].valid = stage_valid[k-1];
      end
   end

   assign req_chan.ready = stage_en[0];

   // segment search
   logic [scs_pkg::HIT_W-1:0]      m_hit;
   logic [scs_pkg::PIX_W-1:0]      m_diff;
   logic [scs_pkg::BOUND_W-1:0]    m_span;

   scs_match #(
      .NUM_SEGMENTS (NUM_SEGMENTS)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stage_ctl[0]),
      .gray_in   (req_chan.gray_in),
      .seg_low   (seg_low_ff),
      .seg_high  (seg_high_ff),
      .valid_out (stage_valid[0]),
      .hit_out   (m_hit),
      .diff_out  (m_diff),
      .span_out  (m_span)
   );

   // scale the offset
   logic                           mul_valid_ff;
   logic [NUM_W-1:0]               num_ff, num_in;
   logic [scs_pkg::BOUND_W-1:0]    mul_span_ff;
   logic [scs_pkg::HIT_W-1:0]      mul_hit_ff;

   assign num_in = NUM_W'(m_diff) * NUM_W'(OUT_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (stage_ctl[1].load) begin
         mul_valid_ff <= stage_ctl[1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ctl[1].load) begin
         num_ff      <= num_in;
         mul_span_ff <= m_span;
         mul_hit_ff  <= m_hit;
      end
   end

   assign stage_valid[1] = mul_valid_ff;

   // divider chain
   logic [DIV_STAGES:0][NUM_W-1:0]              div_rem;
   logic [DIV_STAGES:0][QUO_W-1:0]              div_quo;
   logic [DIV_STAGES:0][scs_pkg::BOUND_W-1:0]   div_span;
   logic [DIV_STAGES:0][scs_pkg::HIT_W-1:0]     div_hit;

   assign div_rem[0]  = num_ff;
   assign div_quo[0]  = '0;
   assign div_span[0] = mul_span_ff;
   assign div_hit[0]  = mul_hit_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      localparam int TOP = QUO_W - 1 - BPS * s;
      localparam int NB  = (TOP + 1 < BPS) ? TOP + 1 : BPS;

      scs_div_stage #(
         .NUM_W   (NUM_W),
         .QUO_W   (QUO_W),
         .TOP_BIT (TOP),
         .STEPS   (NB)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .ctl       (stage_ctl[2+s]),
         .prev_rem  (div_rem[s]),
         .prev_quo  (div_quo[s]),
         .prev_span (div_span[s]),
         .prev_hit  (div_hit[s]),
         .valid_out (stage_valid[2+s]),
         .rem       (div_rem[s+1]),
         .quo       (div_quo[s+1]),
         .span      (div_span[s+1]),
         .hit       (div_hit[s+1])
      );
   end

   // rounding and output register
   scs_round #(
      .QUO_W (QUO_W)
   ) u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (stage_ctl[NST-1]),
      .prev_quo    (div_quo[DIV_STAGES]),
      .prev_rem    (div_rem[DIV_STAGES][scs_pkg::BOUND_W-1:0]),
      .prev_span   (div_span[DIV_STAGES]),
      .prev_hit    (div_hit[DIV_STAGES]),
      .valid_out   (stage_valid[NST-1]),
      .gray_out    (rsp_chan.gray_out),
      .segment_hit (rsp_chan.segment_hit)
   );

   assign rsp_chan.valid = stage_valid[NST-1];

endmodule
`default_nettype wire

// ----- rtl/scs_match.sv -----
// Segment search stage: first matching segment, offset and span
`timescale 1ns / 1ps
`default_nettype none
module scs_match #(
   parameter int NUM_SEGMENTS = 4
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire scs_pkg::stage_ctl_type                            ctl,
   input  wire logic [scs_pkg::PIX_W-1:0]                         gray_in,
   input  wire logic [NUM_SEGMENTS-1:0][scs_pkg::BOUND_W-1:0]     seg_low,
   input  wire logic [NUM_SEGMENTS-1:0][scs_pkg::BOUND_W-1:0]     seg_high,
   output logic                                                   valid_out,
   output logic [scs_pkg::HIT_W-1:0]                              hit_out,
   output logic [scs_pkg::PIX_W-1:0]                              diff_out,
   output logic [scs_pkg::BOUND_W-1:0]                            span_out
);

   logic                           valid_ff;
   logic [scs_pkg::HIT_W-1:0]      hit_ff, hit_in;
   logic [scs_pkg::PIX_W-1:0]      diff_ff, diff_in;
   logic [scs_pkg::BOUND_W-1:0]    span_ff, span_in;

   // walk downwards so the lowest matching index wins
   always_comb begin
      logic [scs_pkg::BOUND_W-1:0] pix9;
      logic [scs_pkg::BOUND_W-1:0] lo;
      logic [scs_pkg::BOUND_W-1:0] hi;
      pix9    = {1'b0, gray_in};
      hit_in  = scs_pkg::NO_HIT;
      diff_in = '0;
      span_in = '0;
      for (int i = NUM_SEGMENTS - 1; i >= 0; i--) begin
         lo = seg_low[i];
         hi = seg_high[i];
         if (lo < hi && pix9 >= lo && pix9 < hi) begin
            hit_in  = scs_pkg::HIT_W'(i);
            diff_in = scs_pkg::PIX_W'(pix9 - lo);
            span_in = hi - lo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         hit_ff  <= hit_in;
         diff_ff <= diff_in;
         span_ff <= span_in;
      end
   end

   assign valid_out = valid_ff;
   assign hit_out   = hit_ff;
   assign diff_out  = diff_ff;
   assign span_out  = span_ff;

endmodule
`default_nettype wire

// ----- rtl/scs_div_stage.sv -----
// Divider stage: STEPS restoring quotient bits per register stage
`timescale 1ns / 1ps
`default_nettype none
module scs_div_stage #(
   parameter int NUM_W   = 17,
   parameter int QUO_W   = 9,
   parameter int TOP_BIT = 8,
   parameter int STEPS   = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire scs_pkg::stage_ctl_type          ctl,
   input  wire logic [NUM_W-1:0]                prev_rem,
   input  wire logic [QUO_W-1:0]                prev_quo,
   input  wire logic [scs_pkg::BOUND_W-1:0]     prev_span,
   input  wire logic [scs_pkg::HIT_W-1:0]       prev_hit,
   output logic                                 valid_out,
   output logic [NUM_W-1:0]                     rem,
   output logic [QUO_W-1:0]                     quo,
   output logic [scs_pkg::BOUND_W-1:0]          span,
   output logic [scs_pkg::HIT_W-1:0]            hit
);

   localparam int CMP_W = NUM_W + QUO_W;

   logic                            valid_ff;
   logic [NUM_W-1:0]                rem_ff, rem_in;
   logic [QUO_W-1:0]                quo_ff, quo_in;
   logic [scs_pkg::BOUND_W-1:0]     span_ff;
   logic [scs_pkg::HIT_W-1:0]       hit_ff;

   // subtract the shifted divisor wherever it fits, one bit at a time
   always_comb begin
      logic [CMP_W-1:0] r;
      logic [CMP_W-1:0] sub;
      r      = CMP_W'(prev_rem);
      quo_in = prev_quo;
      for (int j = 0; j < STEPS; j++) begin
         sub = CMP_W'(prev_span) << (TOP_BIT - j);
         if (r >= sub) begin
            r      = r - sub;
            quo_in = quo_in | (QUO_W'(1) << (TOP_BIT - j));
         end
      end
      rem_in = NUM_W'(r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         span_ff <= prev_span;
         hit_ff  <= prev_hit;
      end
   end

   assign valid_out = valid_ff;
   assign rem       = rem_ff;
   assign quo       = quo_ff;
   assign span      = span_ff;
   assign hit       = hit_ff;

endmodule
`default_nettype wire

// ----- rtl/scs_round.sv -----
// Output stage: round half to even, saturate, blank unmatched pixels
`timescale 1ns / 1ps
`default_nettype none
module scs_round #(
   parameter int QUO_W = 9
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire scs_pkg::stage_ctl_type          ctl,
   input  wire logic [QUO_W-1:0]                prev_quo,
   input  wire logic [scs_pkg::BOUND_W-1:0]     prev_rem,
   input  wire logic [scs_pkg::BOUND_W-1:0]     prev_span,
   input  wire logic [scs_pkg::HIT_W-1:0]       prev_hit,
   output logic                                 valid_out,
   output logic [scs_pkg::PIX_W-1:0]            gray_out,
   output logic [scs_pkg::HIT_W-1:0]            segment_hit
);

   logic                          valid_ff;
   logic [scs_pkg::PIX_W-1:0]     gray_ff, gray_in;
   logic [scs_pkg::HIT_W-1:0]     hit_ff;

   always_comb begin
      logic [scs_pkg::BOUND_W:0] rem2;
      logic [scs_pkg::BOUND_W:0] span2;
      logic                      up;
      logic [QUO_W:0]            q;
      rem2  = {prev_rem, 1'b0};
      span2 = {1'b0, prev_span};
      up    = (rem2 > span2) || (rem2 == span2 && prev_quo[0]);
      q     = {1'b0, prev_quo} + (QUO_W + 1)'(up);
      if (prev_hit == scs_pkg::NO_HIT) begin
         gray_in = '0;
      end else if (32'(q) > 32'd255) begin
         gray_in = '1;
      end else begin
         gray_in = scs_pkg::PIX_W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.load) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         gray_ff <= gray_in;
         hit_ff  <= prev_hit;
      end
   end

   assign valid_out   = valid_ff;
   assign gray_out    = gray_ff;
   assign segment_hit = hit_ff;

endmodule
`default_nettype wire

// ----- rtl/scs_checker.sv -----
// Port checker for the contrast stretch result channel, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "sawtooth_contrast_stretch_macros.svh"
module scs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [scs_pkg::PIX_W-1:0]     rsp_gray_out,
   input wire logic [scs_pkg::HIT_W-1:0]     rsp_segment_hit
);

   // hold a stalled word
   `SCS_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_gray_out) && $stable(rsp_segment_hit))

   // drop everything in flight on reset
   `SCS_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   `SCS_ASSERT_IMP(a_hit_range, clock, reset, rsp_valid, rsp_segment_hit <= scs_pkg::NO_HIT)

   // an unmatched pixel comes out black
   `SCS_ASSERT_IMP(a_miss_black, clock, reset, rsp_valid && rsp_segment_hit == scs_pkg::NO_HIT, rsp_gray_out == '0)

endmodule

bind sawtooth_contrast_stretch scs_checker u_scs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_gray_out    (rsp_chan.gray_out),
   .rsp_segment_hit (rsp_chan.segment_hit)
);
`default_nettype wire
